FILE: hdl/oae_pkg.sv
// Package for the order-1 adaptive arithmetic encoder.
// Holds field widths, coder constants and the count-memory command type.
// No dependencies; every other file of the block uses it.
package oae_pkg;

   localparam int SYMBOL_W = 9;
   localparam int BYTE_W   = 8;
   localparam int NBITS_W  = 4;
   localparam int COUNT_W  = 14;
   localparam int CODE_W   = 16;
   localparam int SPAN_W   = CODE_W + 1;
   localparam int DIVD_W   = SPAN_W + COUNT_W;
   localparam int DCNT_W   = 5;
   localparam int CTX_MAX_W = 8;
   localparam int IDX_MAX_W = 9;

   localparam logic [COUNT_W-1:0] MAX_SCALE_RST = 14'd16383;
   localparam logic [CODE_W-1:0]  HIGH_RST      = 16'hffff;
   localparam logic [CODE_W-1:0]  QUARTER_MASK  = 16'h3fff;
   localparam logic [CODE_W-1:0]  QUARTER_BIT   = 16'h4000;
   localparam logic [NBITS_W-1:0] FULL_BYTE     = 4'd8;

   // Commands from the sequencer to the count memory.
   typedef struct packed {
      logic [CTX_MAX_W-1:0] ctx;
      logic                 rd_en;
      logic [IDX_MAX_W-1:0] rd_idx;
      logic                 wr_en;
      logic [IDX_MAX_W-1:0] wr_idx;
      logic [COUNT_W-1:0]   wr_data;
      logic                 set_valid;
      logic                 clear_all;
   } cnt_cmd_type;

endpackage

FILE: hdl/oae_ifs.sv
// Valid/ready channel interfaces for symbols in and packed code bytes out.
// Depends on oae_pkg for the field widths.
interface oae_req_if;
   logic                          valid;
   logic                          ready;
   logic [oae_pkg::SYMBOL_W-1:0]  symbol;
   modport source (output valid, output symbol, input ready);
   modport sink (input valid, input symbol, output ready);
endinterface

interface oae_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [oae_pkg::BYTE_W-1:0]    out_byte;
   logic [oae_pkg::NBITS_W-1:0]   valid_bits;
   logic                          last;
   logic                          stream_end;
   logic                          pending_overflow;
   modport source (output valid, output out_byte, output valid_bits, output last,
                   output stream_end, output pending_overflow, input ready);
   modport sink (input valid, input out_byte, input valid_bits, input last,
                 input stream_end, input pending_overflow, output ready);
endinterface

FILE: hdl/oae_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on oae_pkg for operand widths.
module oae_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [oae_pkg::DIVD_W-1:0]    dividend,
   input  logic [oae_pkg::COUNT_W-1:0]   divisor,
   output logic                          done,
   output logic [oae_pkg::DIVD_W-1:0]    quotient
);

   logic [oae_pkg::DIVD_W-1:0]  quo_ff, quo_in;
   logic [oae_pkg::COUNT_W-1:0] rem_ff, rem_in;
   logic [oae_pkg::COUNT_W-1:0] dvs_ff, dvs_in;
   logic [oae_pkg::DCNT_W-1:0]  cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [oae_pkg::COUNT_W:0]   trial;
   logic [oae_pkg::COUNT_W:0]   diff;

   // One shift-and-subtract step per cycle while busy.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[oae_pkg::DIVD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = oae_pkg::DCNT_W'(oae_pkg::DIVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[oae_pkg::COUNT_W-1:0];
            quo_in = {quo_ff[oae_pkg::DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[oae_pkg::COUNT_W-1:0];
            quo_in = {quo_ff[oae_pkg::DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == oae_pkg::DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hdl/oae_cnt_mem.sv
// Cumulative-count memory, one row per context, with a valid flag per row.
// A row not yet written reads as identity counts. Depends on oae_pkg.
module oae_cnt_mem #(
   parameter int CTX_N   = 256,
   parameter int ROW_LEN = 258
) (
   input  logic                         clock,
   input  logic                         reset,
   input  oae_pkg::cnt_cmd_type         cmd,
   output logic [oae_pkg::COUNT_W-1:0]  rd_data
);

   localparam int CTX_W = (CTX_N > 1) ? $clog2(CTX_N) : 1;
   localparam int IDX_W = $clog2(ROW_LEN);
   localparam int DEPTH = 2 ** (CTX_W + IDX_W);
   localparam int ROWS  = 2 ** CTX_W;

   logic [oae_pkg::COUNT_W-1:0] mem [0:DEPTH-1];
   logic [ROWS-1:0]             row_valid_ff;
   logic [oae_pkg::COUNT_W-1:0] q_ff;
   logic                        q_valid_ff;
   logic [oae_pkg::IDX_MAX_W-1:0] q_idx_ff;
   logic [CTX_W-1:0]            row;

   assign row = cmd.ctx[CTX_W-1:0];

   // Single write port and single registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[{row, cmd.wr_idx[IDX_W-1:0]}] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         q_ff       <= mem[{row, cmd.rd_idx[IDX_W-1:0]}];
         q_valid_ff <= row_valid_ff[row];
         q_idx_ff   <= cmd.rd_idx;
      end
   end

   // Row flags: all cleared at reset and at the end of a stream.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         row_valid_ff <= '0;
      end else if (cmd.set_valid) begin
         row_valid_ff[row] <= 1'b1;
      end
   end

   assign rd_data = q_valid_ff ? q_ff : oae_pkg::COUNT_W'(q_idx_ff);

endmodule

FILE: hdl/order1_adaptive_arith_encoder_top.sv
// Order-1 adaptive arithmetic encoder: one symbol at a time, bytes out LSB first.
// Each symbol takes the count reads, two divisions and the closing states, then the
// settled bits, the pending bits and underflow steps, a walk over the row for the
// count update, another walk when the context is halved, and the flushed bits at end
// of stream; the next symbol is taken only after the current one is finished.
// Synchronous reset clears the coder at once; row flags give identity counts.
module order1_adaptive_arith_encoder_top #(
   parameter int EOS_SYMBOL    = 256,
   parameter int PENDING_LIMIT = 127
) (
   input  logic                         clock,
   input  logic                         reset,
   oae_req_if.sink                      req_if,
   oae_rsp_if.source                    rsp_if,
   input  logic                         csr_wr_en,
   input  logic [oae_pkg::COUNT_W-1:0]  csr_wr_data
);

   localparam int ROW_LEN = EOS_SYMBOL + 2;
   localparam int WALK_W  = $clog2(ROW_LEN + 1);
   localparam int PEND_W  = $clog2(PENDING_LIMIT + 1);
   localparam int CTX_W   = (EOS_SYMBOL > 1) ? $clog2(EOS_SYMBOL) : 1;
   localparam logic [oae_pkg::SYMBOL_W-1:0]  EOS_CODE  = oae_pkg::SYMBOL_W'(EOS_SYMBOL);
   localparam logic [oae_pkg::IDX_MAX_W-1:0] TOTAL_IDX = oae_pkg::IDX_MAX_W'(EOS_SYMBOL + 1);
   localparam logic [WALK_W-1:0]             WALK_END  = WALK_W'(ROW_LEN);
   localparam logic [PEND_W-1:0]             PEND_MAX  = PEND_W'(PENDING_LIMIT);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_SC, ST_RD_LO, ST_RD_HI, ST_CAP_HI, ST_MUL, ST_DSTART, ST_DWAIT,
      ST_SHIFT, ST_PEND, ST_ADAPT, ST_HALVE, ST_FL_FIRST, ST_FL_PEND, ST_FL_PART, ST_FIN
   } state_type;

   state_type                       state_ff, state_in;
   logic [oae_pkg::SYMBOL_W-1:0]    sym_ff, sym_in;
   logic [CTX_W-1:0]                ctx_ff, ctx_in;
   logic [oae_pkg::CODE_W-1:0]      low_ff, low_in, high_ff, high_in;
   logic [oae_pkg::CODE_W-1:0]      new_high_ff, new_high_in;
   logic [PEND_W-1:0]               pend_ff, pend_in;
   logic [PEND_W:0]                 fcnt_ff, fcnt_in;
   logic                            ovf_ff, ovf_in;
   logic [oae_pkg::BYTE_W-1:0]      acc_ff, acc_in;
   logic [2:0]                      fill_ff, fill_in;
   logic [oae_pkg::COUNT_W-1:0]     max_scale_ff, max_scale_in;
   logic [oae_pkg::COUNT_W-1:0]     scale_ff, scale_in, lc_ff, lc_in, hc_ff, hc_in;
   logic [oae_pkg::COUNT_W-1:0]     prev_new_ff, prev_new_in;
   logic [oae_pkg::DIVD_W-1:0]      prod_ff, prod_in;
   logic                            sel_lo_ff, sel_lo_in;
   logic                            ubit_ff, ubit_in;
   logic [WALK_W-1:0]               walk_ff, walk_in;
   logic                            held_valid_ff, held_valid_in;
   logic [oae_pkg::BYTE_W-1:0]      held_byte_ff, held_byte_in;
   logic [oae_pkg::NBITS_W-1:0]     held_nbits_ff, held_nbits_in;
   logic                            held_ovf_ff, held_ovf_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [oae_pkg::BYTE_W-1:0]      rsp_byte_ff, rsp_byte_in;
   logic [oae_pkg::NBITS_W-1:0]     rsp_nbits_ff, rsp_nbits_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic                            rsp_end_ff, rsp_end_in;
   logic                            rsp_ovf_ff, rsp_ovf_in;

   oae_pkg::cnt_cmd_type            mem_cmd;
   logic [oae_pkg::COUNT_W-1:0]     mem_q;
   logic                            div_start, div_done;
   logic [oae_pkg::DIVD_W-1:0]      div_q;
   logic [oae_pkg::COUNT_W-1:0]     divisor;
   logic [oae_pkg::CODE_W-1:0]      q16;
   logic [oae_pkg::SPAN_W-1:0]      span;
   logic [oae_pkg::COUNT_W-1:0]     mul_op;
   logic                            out_free;
   logic                            put_req, put_val, part_req;
   logic [oae_pkg::BYTE_W-1:0]      acc_put;
   logic                            byte_full, emit_req, stall;
   logic [oae_pkg::BYTE_W-1:0]      emit_byte;
   logic [oae_pkg::NBITS_W-1:0]     emit_nbits;
   logic [oae_pkg::IDX_MAX_W-1:0]   wr_idx;
   logic [oae_pkg::COUNT_W-1:0]     wr_val, half_val;
   logic                            is_eos;

   oae_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   oae_cnt_mem #(
      .CTX_N   (EOS_SYMBOL),
      .ROW_LEN (ROW_LEN)
   ) u_cnt_mem (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_cmd),
      .rd_data (mem_q)
   );

   // Shared datapath terms.
   assign divisor  = (scale_ff == '0) ? oae_pkg::COUNT_W'(1) : scale_ff;
   assign q16      = div_q[oae_pkg::CODE_W-1:0];
   assign span     = {1'b0, high_ff} - {1'b0, low_ff} + oae_pkg::SPAN_W'(1);
   assign mul_op   = sel_lo_ff ? lc_ff : hc_ff;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign is_eos   = (sym_ff == EOS_CODE);
   assign wr_idx   = oae_pkg::IDX_MAX_W'(walk_ff - 1'b1);
   assign half_val = {1'b0, mem_q[oae_pkg::COUNT_W-1:1]};

   // Bit packing: which bit goes out this cycle, and whether it completes a byte.
   always_comb begin
      put_req  = 1'b0;
      put_val  = 1'b0;
      part_req = 1'b0;
      case (state_ff)
         ST_SHIFT: begin
            put_req = (high_ff[oae_pkg::CODE_W-1] == low_ff[oae_pkg::CODE_W-1]);
            put_val = high_ff[oae_pkg::CODE_W-1];
         end
         ST_PEND: begin
            put_req = (pend_ff != '0);
            put_val = ubit_ff;
         end
         ST_FL_FIRST: begin
            put_req = 1'b1;
            put_val = low_ff[oae_pkg::CODE_W-2];
         end
         ST_FL_PEND: begin
            put_req = (fcnt_ff != '0);
            put_val = !low_ff[oae_pkg::CODE_W-2];
         end
         ST_FL_PART: part_req = (fill_ff != '0);
         default: ;
      endcase
      acc_put    = acc_ff | (oae_pkg::BYTE_W'(put_val) << fill_ff);
      byte_full  = put_req && (fill_ff == 3'd7);
      emit_req   = byte_full || part_req;
      emit_byte  = byte_full ? acc_put : acc_ff;
      emit_nbits = byte_full ? oae_pkg::FULL_BYTE : oae_pkg::NBITS_W'(fill_ff);
      stall      = emit_req && held_valid_ff && !out_free;
   end

   // Sequencer and datapath next state.
   always_comb begin
      state_in      = state_ff;
      sym_in        = sym_ff;
      ctx_in        = ctx_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      new_high_in   = new_high_ff;
      pend_in       = pend_ff;
      fcnt_in       = fcnt_ff;
      ovf_in        = ovf_ff;
      acc_in        = acc_ff;
      fill_in       = fill_ff;
      max_scale_in  = csr_wr_en ? csr_wr_data : max_scale_ff;
      scale_in      = scale_ff;
      lc_in         = lc_ff;
      hc_in         = hc_ff;
      prev_new_in   = prev_new_ff;
      prod_in       = prod_ff;
      sel_lo_in     = sel_lo_ff;
      ubit_in       = ubit_ff;
      walk_in       = walk_ff;
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      held_nbits_in = held_nbits_ff;
      held_ovf_in   = held_ovf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_nbits_in  = rsp_nbits_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      div_start     = 1'b0;
      wr_val        = mem_q;
      mem_cmd       = '0;
      mem_cmd.ctx   = oae_pkg::CTX_MAX_W'(ctx_ff);

      // A finished byte moves into the holding stage; the one held before leaves.
      if (emit_req && !stall) begin
         if (held_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = held_byte_ff;
            rsp_nbits_in = held_nbits_ff;
            rsp_last_in  = 1'b0;
            rsp_end_in   = 1'b0;
            rsp_ovf_in   = held_ovf_ff;
         end
         held_valid_in = 1'b1;
         held_byte_in  = emit_byte;
         held_nbits_in = emit_nbits;
         held_ovf_in   = ovf_ff;
      end
      if (put_req && !stall) begin
         acc_in  = byte_full ? '0 : acc_put;
         fill_in = fill_ff + 3'd1;
      end
      if (part_req && !stall) begin
         acc_in  = '0;
         fill_in = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid && (req_if.symbol <= EOS_CODE)) begin
               sym_in   = req_if.symbol;
               state_in = ST_RD_SC;
            end
         end
         ST_RD_SC: begin
            mem_cmd.rd_en  = 1'b1;
            mem_cmd.rd_idx = TOTAL_IDX;
            state_in       = ST_RD_LO;
         end
         ST_RD_LO: begin
            scale_in       = mem_q;
            mem_cmd.rd_en  = 1'b1;
            mem_cmd.rd_idx = sym_ff;
            state_in       = ST_RD_HI;
         end
         ST_RD_HI: begin
            lc_in          = mem_q;
            mem_cmd.rd_en  = 1'b1;
            mem_cmd.rd_idx = sym_ff + 1'b1;
            state_in       = ST_CAP_HI;
         end
         ST_CAP_HI: begin
            hc_in     = mem_q;
            sel_lo_in = 1'b0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = oae_pkg::DIVD_W'(span) * oae_pkg::DIVD_W'(mul_op);
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_done) begin
               if (!sel_lo_ff) begin
                  new_high_in = low_ff + q16 - oae_pkg::CODE_W'(1);
                  sel_lo_in   = 1'b1;
                  state_in    = ST_MUL;
               end else begin
                  low_in   = low_ff + q16;
                  high_in  = new_high_ff;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (put_req) begin
               if (!stall) begin
                  ubit_in  = !high_ff[oae_pkg::CODE_W-1];
                  state_in = ST_PEND;
               end
            end else if (low_ff[oae_pkg::CODE_W-2] && !high_ff[oae_pkg::CODE_W-2]) begin
               // Underflow: count a pending bit, saturating at the limit.
               if (pend_ff >= PEND_MAX) begin
                  pend_in = PEND_MAX;
                  ovf_in  = 1'b1;
               end else begin
                  pend_in = pend_ff + 1'b1;
               end
               low_in  = (low_ff & oae_pkg::QUARTER_MASK) << 1;
               high_in = ((high_ff | oae_pkg::QUARTER_BIT) << 1) | oae_pkg::CODE_W'(1);
            end else if (is_eos) begin
               state_in = ST_FL_FIRST;
            end else begin
               walk_in  = '0;
               state_in = ST_ADAPT;
            end
         end
         ST_PEND: begin
            if (put_req) begin
               if (!stall) begin
                  pend_in = pend_ff - 1'b1;
               end
            end else begin
               low_in   = low_ff << 1;
               high_in  = (high_ff << 1) | oae_pkg::CODE_W'(1);
               state_in = ST_SHIFT;
            end
         end
         ST_ADAPT: begin
            // Read entry k while entry k-1 is written back, incremented if it lies above the symbol.
            if (walk_ff != WALK_END) begin
               mem_cmd.rd_en  = 1'b1;
               mem_cmd.rd_idx = oae_pkg::IDX_MAX_W'(walk_ff);
            end
            wr_val = (wr_idx > sym_ff) ? mem_q + 1'b1 : mem_q;
            if (walk_ff != '0) begin
               mem_cmd.wr_en   = 1'b1;
               mem_cmd.wr_idx  = wr_idx;
               mem_cmd.wr_data = wr_val;
            end
            walk_in = walk_ff + 1'b1;
            if (walk_ff == WALK_END) begin
               mem_cmd.set_valid = 1'b1;
               walk_in           = '0;
               state_in          = (wr_val >= max_scale_ff) ? ST_HALVE : ST_FIN;
            end
         end
         ST_HALVE: begin
            // Halve each count, keeping the row strictly increasing.
            if (walk_ff != WALK_END) begin
               mem_cmd.rd_en  = 1'b1;
               mem_cmd.rd_idx = oae_pkg::IDX_MAX_W'(walk_ff);
            end
            if (wr_idx == '0) begin
               wr_val = mem_q;
            end else if (half_val <= prev_new_ff) begin
               wr_val = prev_new_ff + 1'b1;
            end else begin
               wr_val = half_val;
            end
            if (walk_ff != '0) begin
               mem_cmd.wr_en   = 1'b1;
               mem_cmd.wr_idx  = wr_idx;
               mem_cmd.wr_data = wr_val;
               prev_new_in     = wr_val;
            end
            walk_in = walk_ff + 1'b1;
            if (walk_ff == WALK_END) begin
               walk_in  = '0;
               state_in = ST_FIN;
            end
         end
         ST_FL_FIRST: begin
            if (!stall) begin
               fcnt_in  = {1'b0, pend_ff} + 1'b1;
               state_in = ST_FL_PEND;
            end
         end
         ST_FL_PEND: begin
            if (put_req) begin
               if (!stall) begin
                  fcnt_in = fcnt_ff - 1'b1;
               end
            end else begin
               pend_in  = '0;
               state_in = ST_FL_PART;
            end
         end
         ST_FL_PART: begin
            if (!stall) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Release the held byte as the step's final transfer.
            if (!held_valid_ff || out_free) begin
               if (held_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_byte_in   = held_byte_ff;
                  rsp_nbits_in  = held_nbits_ff;
                  rsp_last_in   = 1'b1;
                  rsp_end_in    = is_eos;
                  rsp_ovf_in    = held_ovf_ff;
                  held_valid_in = 1'b0;
               end
               if (is_eos) begin
                  low_in            = '0;
                  high_in           = oae_pkg::HIGH_RST;
                  pend_in           = '0;
                  ctx_in            = '0;
                  acc_in            = '0;
                  fill_in           = '0;
                  ovf_in            = 1'b0;
                  mem_cmd.clear_all = 1'b1;
               end else begin
                  ctx_in = sym_ff[CTX_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ctx_ff        <= '0;
         low_ff        <= '0;
         high_ff       <= oae_pkg::HIGH_RST;
         pend_ff       <= '0;
         ovf_ff        <= 1'b0;
         acc_ff        <= '0;
         fill_ff       <= '0;
         max_scale_ff  <= oae_pkg::MAX_SCALE_RST;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         walk_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         ctx_ff        <= ctx_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
         pend_ff       <= pend_in;
         ovf_ff        <= ovf_in;
         acc_ff        <= acc_in;
         fill_ff       <= fill_in;
         max_scale_ff  <= max_scale_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         walk_ff       <= walk_in;
      end
      sym_ff        <= sym_in;
      new_high_ff   <= new_high_in;
      fcnt_ff       <= fcnt_in;
      scale_ff      <= scale_in;
      lc_ff         <= lc_in;
      hc_ff         <= hc_in;
      prev_new_ff   <= prev_new_in;
      prod_ff       <= prod_in;
      sel_lo_ff     <= sel_lo_in;
      ubit_ff       <= ubit_in;
      held_byte_ff  <= held_byte_in;
      held_nbits_ff <= held_nbits_in;
      held_ovf_ff   <= held_ovf_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_nbits_ff  <= rsp_nbits_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign req_if.ready            = (state_ff == ST_IDLE);
   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.out_byte         = rsp_byte_ff;
   assign rsp_if.valid_bits       = rsp_nbits_ff;
   assign rsp_if.last             = rsp_last_ff;
   assign rsp_if.stream_end       = rsp_end_ff;
   assign rsp_if.pending_overflow = rsp_ovf_ff;

`ifndef SYNTHESIS
   // Every symbol's bytes have left the holding stage before the next is taken.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !held_valid_ff)
      else $error("holding stage still full while idle");

   // Between symbols the interval always straddles the midpoint.
   a_idle_straddle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> high_ff[oae_pkg::CODE_W-1] != low_ff[oae_pkg::CODE_W-1])
      else $error("interval left unnormalised");

   // The divider only finishes while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DWAIT)
      else $error("divider result arrived outside its wait state");

   // The pending-bit counter never passes its limit.
   a_pend_limit: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PEND_MAX)
      else $error("pending count above limit");
`endif

endmodule

FILE: bench/tb_oae_ifs.sv
// Interface instances are taken from the RTL file oae_ifs.sv; this file adds
// nothing but a small helper package for the bench's message limits.
// No dependencies.
package tb_oae_util_pkg;
   localparam int MISMATCH_REPORT_MAX = 10;
endpackage

FILE: bench/oae_scoreboard.sv
// Checker for the order-1 arithmetic encoder: watches the symbol and byte channels,
// predicts the packed code bytes and compares every result transfer in order.
// Depends on oae_pkg, oae_ifs and tb_oae_util_pkg.
module oae_scoreboard (
   input  logic                         clock,
   input  logic                         reset,
   oae_req_if.sink                      req_mon,
   oae_rsp_if.sink                      rsp_mon,
   input  logic                         csr_wr_en,
   input  logic [oae_pkg::COUNT_W-1:0]  csr_wr_data,
   output int                           fail_count,
   output int                           bytes_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EOS = 256;
   localparam int ROWN = EOS + 2;
   localparam int PLIM = 127;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [3:0] valid_bits;
      logic       last;
      logic       stream_end;
      logic       pending_overflow;
   } code_byte_type;

   code_byte_type byte_queue[$];
   code_byte_type step_bytes[$];

   logic [oae_pkg::COUNT_W-1:0] ctx_counts [EOS][ROWN];
   int unsigned lo_q, hi_q, underflow_n, prev_sym, acc, fill, ovf, scale_limit;
   int mismatches;

   // Restart the coding state for a new stream.
   task automatic restart_stream();
      for (int c = 0; c < EOS; c++)
         for (int i = 0; i < ROWN; i++) ctx_counts[c][i] = oae_pkg::COUNT_W'(i);
      lo_q = 0; hi_q = 16'hffff; underflow_n = 0; prev_sym = 0;
      acc = 0; fill = 0; ovf = 0;
   endtask

   task automatic push_byte(int unsigned b, int unsigned n);
      code_byte_type e;
      e.out_byte = 8'(b); e.valid_bits = 4'(n); e.last = 0; e.stream_end = 0;
      e.pending_overflow = ovf[0];
      step_bytes.push_back(e);
   endtask

   task automatic shift_bit(int unsigned bit_v);
      if (bit_v != 0) acc = acc | (1 << fill);
      fill++;
      if (fill == 8) begin
         push_byte(acc, 8);
         acc = 0; fill = 0;
      end
   endtask

   // Encode one symbol and collect the bytes it settles.
   task automatic predict_step(int unsigned sym);
      int unsigned ctx, tot, lc, hc, span, base, n, v;
      step_bytes.delete();
      ctx = prev_sym;
      tot = ctx_counts[ctx][EOS + 1]; lc = ctx_counts[ctx][sym];
      hc = ctx_counts[ctx][sym + 1];
      if (tot == 0) tot = 1;
      span = hi_q - lo_q + 1; base = lo_q;
      hi_q = (base + (span * hc / tot - 1)) & 16'hffff;
      lo_q = (base + span * lc / tot) & 16'hffff;
      forever begin
         if ((hi_q & 16'h8000) == (lo_q & 16'h8000)) begin
            shift_bit(hi_q & 16'h8000);
            while (underflow_n > 0) begin
               shift_bit(~hi_q & 16'h8000);
               underflow_n--;
            end
         end else if ((lo_q & 16'h4000) != 0 && (hi_q & 16'h4000) == 0) begin
            if (underflow_n >= PLIM) begin
               underflow_n = PLIM; ovf = 1;
            end else underflow_n++;
            lo_q &= 16'h3fff; hi_q |= 16'h4000;
         end else break;
         lo_q = (lo_q << 1) & 16'hffff;
         hi_q = ((hi_q << 1) | 1) & 16'hffff;
      end
      if (sym < EOS) begin
         // Adapt the context, halving it once the total reaches the limit.
         for (int i = sym + 1; i < ROWN; i++) ctx_counts[ctx][i] = ctx_counts[ctx][i] + 1'b1;
         if (ctx_counts[ctx][EOS + 1] >= scale_limit) begin
            for (int i = 1; i < ROWN; i++) begin
               v = ctx_counts[ctx][i] / 2;
               if (v <= ctx_counts[ctx][i - 1]) v = ctx_counts[ctx][i - 1] + 1;
               ctx_counts[ctx][i] = oae_pkg::COUNT_W'(v);
            end
         end
         prev_sym = sym;
      end else begin
         // Flush two bits plus the underflow bits, then the partial byte.
         shift_bit(lo_q & 16'h4000);
         n = underflow_n + 1;
         while (n > 0) begin
            shift_bit(~lo_q & 16'h4000);
            n--;
         end
         underflow_n = 0;
         if (fill > 0) push_byte(acc, fill);
         if (step_bytes.size() > 0) step_bytes[$].stream_end = 1;
         restart_stream();
      end
      if (step_bytes.size() > 0) step_bytes[$].last = 1;
      foreach (step_bytes[k]) byte_queue.push_back(step_bytes[k]);
   endtask

   assign bytes_pending = byte_queue.size();
   assign fail_count = mismatches;

   // Predict on every accepted symbol (code at most EOS) and compare on every byte transfer.
   always @(posedge clock) begin
      code_byte_type want, got;
      if (reset) begin
         restart_stream();
         scale_limit = 16383;
         byte_queue.delete();
      end else begin
         if (csr_wr_en) scale_limit = csr_wr_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.out_byte, rsp_mon.valid_bits, rsp_mon.last,
                   rsp_mon.stream_end, rsp_mon.pending_overflow};
            if (byte_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= tb_oae_util_pkg::MISMATCH_REPORT_MAX)
                  $display("unexpected byte transfer: %p", got);
            end else begin
               want = byte_queue.pop_front();
               if (want != got) begin
                  mismatches++;
                  if (mismatches <= tb_oae_util_pkg::MISMATCH_REPORT_MAX)
                     $display("byte mismatch: expected %p actual %p", want, got);
               end
            end
         end
         if (req_mon.valid && req_mon.ready && req_mon.symbol <= EOS)
            predict_step(req_mon.symbol);
      end
   end

   initial mismatches = 0;
endmodule

FILE: bench/tb_order1_adaptive_arith_encoder_top.sv
// Top of the encoder bench: clock, reset, symbol stimulus, register writes and verdict.
// Depends on oae_pkg, oae_ifs, oae_scoreboard and the encoder RTL.
module tb_order1_adaptive_arith_encoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EOS = 256;
   localparam longint CYCLE_LIMIT = 5_000_000;

   logic clock, reset, csr_wr_en;
   logic [oae_pkg::COUNT_W-1:0] csr_wr_data;
   logic burst_mode;
   longint cycles;
   int fail_count, bytes_pending;

   oae_req_if req_ch();
   oae_rsp_if rsp_ch();

   order1_adaptive_arith_encoder_top dut (
      .clock(clock), .reset(reset), .req_if(req_ch.sink), .rsp_if(rsp_ch.source),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data));

   oae_scoreboard checker_u (
      .clock(clock), .reset(reset), .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .bytes_pending(bytes_pending));

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver stalls at random except during the burst stretch.
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 0;
      else rsp_ch.ready <= burst_mode || ($urandom_range(99) >= 15);
   end

   // Cycle limit watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Offer one symbol, with a random gap first outside burst mode, and wait for its transfer.
   task automatic send_symbol(int unsigned sym);
      while (!burst_mode && $urandom_range(99) < 15) @(posedge clock);
      req_ch.valid <= 1;
      req_ch.symbol <= 9'(sym);
      do @(posedge clock); while (!req_ch.ready);
      req_ch.valid <= 0;
      @(posedge clock);
   endtask

   // Let the block drain before a register write.
   task automatic wait_idle();
      while (bytes_pending != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   task automatic write_scale(int unsigned v);
      wait_idle();
      csr_wr_en <= 1;
      csr_wr_data <= oae_pkg::COUNT_W'(v);
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic int unsigned random_symbol(int unsigned skew);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 2) return $urandom_range(511, 257);
      if (r < 5) return EOS;
      if (skew != 0 && r < 60) return $urandom_range(3);
      return $urandom_range(255);
   endfunction

   initial begin
      int unsigned directed [] = '{0, 255, 0, 0, 1, 128, 511, 257, 256,
                                   255, 255, 255, 170, 85, 256};
      int unsigned scales [] = '{16383, 258, 300, 1000, 16383};
      cycles = 0;
      burst_mode = 0;
      reset = 1;
      csr_wr_en = 0;
      csr_wr_data = '0;
      req_ch.valid = 0;
      req_ch.symbol = '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: field extremes, ignored codes, end of stream.
      foreach (directed[k]) send_symbol(directed[k]);
      // A long run of one symbol drives the interval toward underflow.
      repeat (10) send_symbol(0);
      send_symbol(EOS);

      // Random phases over several halving limits, smallest among them.
      foreach (scales[p]) begin
         write_scale(scales[p]);
         if (p == 2) burst_mode <= 1;
         for (int i = 0; i < 80; i++) send_symbol(random_symbol(p % 2));
         send_symbol(EOS);
         burst_mode <= 0;
      end

      wait_idle();
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

FILE: sim.f
hdl/oae_pkg.sv
hdl/oae_ifs.sv
hdl/oae_div.sv
hdl/oae_cnt_mem.sv
hdl/order1_adaptive_arith_encoder_top.sv
bench/tb_oae_ifs.sv
bench/oae_scoreboard.sv
bench/tb_order1_adaptive_arith_encoder_top.sv
